FILE: rtl/gskrf_pkg.sv
package gskrf_pkg;

   // Field widths
   localparam int RPM_W  = 20;
   localparam int VAR_W  = 48;
   localparam int UPD_W  = 16;
   localparam int STRK_W = 8;
   localparam int REJ_W  = 16;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 96;

   // Serial unit geometry
   localparam int MA_W   = 48;
   localparam int MB_W   = 28;
   localparam int ACC_W  = MA_W + MB_W;
   localparam int DN_W   = 56;
   localparam int DD_W   = 40;
   localparam int CNT_W  = 6;
   localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MB_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DN_W - 1);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(DN_W / 2 - 1);

   // Tuning constants
   localparam logic [VAR_W-1:0] INIT_VAR = 48'd6400;
   localparam logic [VAR_W-1:0] LEGACY_Q = 48'd400;
   localparam logic [VAR_W-1:0] Q_FLOOR  = 48'd16;
   localparam logic [VAR_W-1:0] P_FLOOR  = 48'd16;
   localparam logic [VAR_W-1:0] VAR_MAX  = {VAR_W{1'b1}};
   localparam logic [18:0]      MAX_PREDICT_US = 19'd500000;
   localparam logic [24:0]      ONE_Q24  = 25'h1000000;
   localparam logic [29:0]      MEAS_DEN_K = 30'd960000000;
   localparam logic [DD_W-1:0]  US_PER_MS  = 40'd1000;
   localparam logic [UPD_W-1:0] GATE_PRIME_UPDATES = 16'd4;
   localparam logic [9:0]       RPP_DEFAULT = 10'd256;

   localparam logic [1:0] MODE_RAW    = 2'd0;
   localparam logic [1:0] MODE_LEGACY = 2'd1;
   localparam logic [1:0] MODE_SMOOTH = 2'd2;

   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_STOP    = 1'b1;

   typedef enum logic [2:0] {
      REG_MODE       = 3'd0,
      REG_RPP        = 3'd1,
      REG_PROC_RATE  = 3'd2,
      REG_MEAS_BASE  = 3'd3,
      REG_JITTER     = 3'd4,
      REG_CYCLE_VAR  = 3'd5,
      REG_GATE_SIG   = 3'd6,
      REG_GATE_MAX   = 3'd7
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_Q1, ST_Q2, ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_R7,
      ST_G0, ST_G1, ST_P0, ST_P1, ST_N0, ST_N1, ST_C0, ST_C1, ST_V0, ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      U_MUL, U_DIV, U_SQRT
   } unit_type;

   function automatic logic [VAR_W-1:0] sat_add(input logic [VAR_W-1:0] a,
                                                 input logic [VAR_W-1:0] b);
      logic [VAR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[VAR_W] ? VAR_MAX : s[VAR_W-1:0];
   endfunction

endpackage

FILE: rtl/gated_scalar_kalman_rpm_filter.sv
// Stop ops, empty items, raw mode and the first smooth item give their result without the
//   serial unit; legacy and smooth items run it, and a gated outlier ends at the gate test.
// Throughput: one item at a time, set by the shared bit-serial multiply/divide/root unit
//   (one bit per cycle); a new item is taken while a result waits.
// Reset: synchronous, active high; register defaults, zero estimate and counters, initial variance.
module gated_scalar_kalman_rpm_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: rpm_measured[19:0], period_count[27:20], dt_us[51:28], zero fill
   input  logic [55:0] req_tdata,
   // tuser: op
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: accepted[0], estimate_rpm[20:1], variance_out[68:21],
   //        rejected_count[84:69], strike_count[92:85], zero fill
   output logic [95:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import gskrf_pkg::*;

   // Configuration registers
   logic [1:0]  mode_ff, mode_in;
   logic [9:0]  rpp_ff, rpp_in;
   logic [31:0] prate_ff, prate_in;
   logic [31:0] mbase_ff, mbase_in;
   logic [15:0] jit_ff, jit_in;
   logic [15:0] cvar_ff, cvar_in;
   logic [7:0]  gsig_ff, gsig_in;
   logic [7:0]  gmax_ff, gmax_in;

   // Filter state
   logic [RPM_W-1:0]  est_ff, est_in;
   logic [VAR_W-1:0]  var_ff, var_in;
   logic [UPD_W-1:0]  upd_ff, upd_in;
   logic [STRK_W-1:0] strk_ff, strk_in;
   logic [REJ_W-1:0]  rej_ff, rej_in;

   // Sequencer and serial unit control
   state_type         state_ff, state_in;
   logic              busy_ff, busy_in;
   unit_type          kind_ff, kind_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Work registers (no reset)
   logic [RPM_W-1:0]  meas_ff, meas_in;
   logic [7:0]        nper_ff, nper_in;
   logic [VAR_W-1:0]  q_ff, q_in;
   logic [VAR_W-1:0]  r_ff, r_in;
   logic [RPM_W-1:0]  tmp_ff, tmp_in;
   logic [24:0]       g_ff, g_in;
   logic              flag_ff, flag_in;
   logic [MA_W-1:0]   ma_ff, ma_in;
   logic [MB_W-1:0]   mb_ff, mb_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [DN_W-1:0]   dn_ff, dn_in;
   logic [DD_W-1:0]   dd_ff, dd_in;
   logic [DD_W-1:0]   rem_ff, rem_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Input item fields
   logic              op_w;
   logic [RPM_W-1:0]  rpm_w;
   logic [7:0]        per_w;
   logic [23:0]       dt_w;
   logic [18:0]       dtc_w;
   logic              req_acc_w;
   logic              legacy_w;

   // Datapath helpers
   logic [RPM_W-1:0]  d_w;
   logic [9:0]        p_w;
   logic [VAR_W-1:0]  var_q_w, gate_sum_w, den_w, s2_w, x_w, vnew_w;
   logic [MB_W-1:0]   s_w;
   logic [45:0]       corr_sum_w;
   logic [21:0]       corr_raw_w;
   logic [RPM_W-1:0]  corr_w;
   logic              outlier_w;
   logic [STRK_W-1:0] strk_inc_w;
   logic [REJ_W-1:0]  rej_inc_w;
   logic [UPD_W-1:0]  upd_inc_w;
   logic [24:0]       g_w;

   // Serial step helpers
   logic [DD_W:0]     dt_trial_w;
   logic              dbit_w;
   logic [30:0]       sq_t_w;
   logic [30:0]       sq_trial_w;
   logic              sbit_w;

   assign op_w   = req_tuser;
   assign rpm_w  = req_tdata[19:0];
   assign per_w  = req_tdata[27:20];
   assign dt_w   = req_tdata[51:28];
   assign dtc_w  = (dt_w > {5'b0, MAX_PREDICT_US}) ? MAX_PREDICT_US : dt_w[18:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc_w  = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign legacy_w   = (mode_ff == MODE_LEGACY);

   assign d_w = (meas_ff >= est_ff) ? meas_ff - est_ff : est_ff - meas_ff;
   assign p_w = (rpp_ff == 10'd0) ? RPP_DEFAULT : rpp_ff;
   assign var_q_w    = sat_add(var_ff, q_ff);
   assign gate_sum_w = sat_add(var_q_w, r_ff);
   assign den_w      = sat_add(var_ff, r_ff);
   assign s2_w = (acc_ff[55:52] != 4'd0) ? VAR_MAX : acc_ff[51:4];
   assign x_w  = sat_add({16'b0, mbase_ff}, s2_w);
   assign s_w  = dn_ff[MB_W-1:0] + {8'b0, tmp_ff};
   assign corr_sum_w = acc_ff[45:0] + 46'h800000;
   assign corr_raw_w = corr_sum_w[45:24];
   assign corr_w = (corr_raw_w > {2'b0, d_w}) ? d_w : corr_raw_w[19:0];
   assign outlier_w  = {52'b0, d_w, 4'b0} > acc_ff;
   assign strk_inc_w = (strk_ff == 8'hFF) ? strk_ff : strk_ff + 8'd1;
   assign rej_inc_w  = (rej_ff == 16'hFFFF) ? rej_ff : rej_ff + 16'd1;
   assign upd_inc_w  = (upd_ff == 16'hFFFF) ? upd_ff : upd_ff + 16'd1;
   assign vnew_w = (acc_ff[71:24] < P_FLOOR) ? P_FLOOR : acc_ff[71:24];
   assign g_w = (dn_ff > {31'b0, ONE_Q24}) ? ONE_Q24 : dn_ff[24:0];

   // Restoring divide step: one quotient bit
   assign dt_trial_w = {rem_ff, dn_ff[DN_W-1]};
   assign dbit_w     = dt_trial_w >= {1'b0, dd_ff};
   // Square root step: two radicand bits in, one root bit out
   assign sq_t_w     = {rem_ff[28:0], dn_ff[DN_W-1:DN_W-2]};
   assign sq_trial_w = {1'b0, mb_ff, 2'b01};
   assign sbit_w     = sq_t_w >= sq_trial_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SMOOTH;
         rpp_ff       <= 10'd256;
         prate_ff     <= 32'd16000;
         mbase_ff     <= 32'd1600;
         jit_ff       <= 16'd256;
         cvar_ff      <= 16'd655;
         gsig_ff      <= 8'd48;
         gmax_ff      <= 8'd3;
         est_ff       <= '0;
         var_ff       <= INIT_VAR;
         upd_ff       <= '0;
         strk_ff      <= '0;
         rej_ff       <= '0;
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         kind_ff      <= U_MUL;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rpp_ff       <= rpp_in;
         prate_ff     <= prate_in;
         mbase_ff     <= mbase_in;
         jit_ff       <= jit_in;
         cvar_ff      <= cvar_in;
         gsig_ff      <= gsig_in;
         gmax_ff      <= gmax_in;
         est_ff       <= est_in;
         var_ff       <= var_in;
         upd_ff       <= upd_in;
         strk_ff      <= strk_in;
         rej_ff       <= rej_in;
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         kind_ff      <= kind_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff     <= meas_in;
      nper_ff     <= nper_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      tmp_ff      <= tmp_in;
      g_ff        <= g_in;
      flag_ff     <= flag_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      acc_ff      <= acc_in;
      dn_ff       <= dn_in;
      dd_ff       <= dd_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      mode_in  = mode_ff;
      rpp_in   = rpp_ff;
      prate_in = prate_ff;
      mbase_in = mbase_ff;
      jit_in   = jit_ff;
      cvar_in  = cvar_ff;
      gsig_in  = gsig_ff;
      gmax_in  = gmax_ff;
      est_in   = est_ff;
      var_in   = var_ff;
      upd_in   = upd_ff;
      strk_in  = strk_ff;
      rej_in   = rej_ff;
      state_in = state_ff;
      busy_in  = busy_ff;
      kind_in  = kind_ff;
      cnt_in   = cnt_ff;
      meas_in  = meas_ff;
      nper_in  = nper_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      tmp_in   = tmp_ff;
      g_in     = g_ff;
      flag_in  = flag_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      acc_in   = acc_ff;
      dn_in    = dn_ff;
      dd_in    = dd_ff;
      rem_in   = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // Configuration writes
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_MODE:      mode_in  = csr_data[1:0];
            REG_RPP:       rpp_in   = csr_data[9:0];
            REG_PROC_RATE: prate_in = csr_data;
            REG_MEAS_BASE: mbase_in = csr_data;
            REG_JITTER:    jit_in   = csr_data[15:0];
            REG_CYCLE_VAR: cvar_in  = csr_data[15:0];
            REG_GATE_SIG:  gsig_in  = csr_data[7:0];
            REG_GATE_MAX:  gmax_in  = csr_data[7:0];
         endcase
      end

      // Advance the serial unit by one bit
      if (busy_ff) begin
         unique case (kind_ff)
            U_MUL: begin
               acc_in = {acc_ff[ACC_W-2:0], 1'b0} +
                        (mb_ff[MB_W-1] ? {{MB_W{1'b0}}, ma_ff} : {ACC_W{1'b0}});
               mb_in  = {mb_ff[MB_W-2:0], 1'b0};
            end
            U_DIV: begin
               rem_in = dbit_w ? DD_W'(dt_trial_w - {1'b0, dd_ff}) : dt_trial_w[DD_W-1:0];
               dn_in  = {dn_ff[DN_W-2:0], dbit_w};
            end
            default: begin
               rem_in = {9'b0, (sbit_w ? sq_t_w - sq_trial_w : sq_t_w)};
               mb_in  = {mb_ff[MB_W-2:0], sbit_w};
               dn_in  = {dn_ff[DN_W-3:0], 2'b00};
            end
         endcase
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) busy_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc_w) begin
               meas_in = rpm_w;
               nper_in = per_w;
               flag_in = 1'b0;
               state_in = ST_FIN;
               if (op_w == OP_STOP) begin
                  // Engine stop: drop the estimate, keep the rejection total
                  est_in  = '0;
                  var_in  = INIT_VAR;
                  upd_in  = '0;
                  strk_in = '0;
               end else if (per_w == 8'd0) begin
                  flag_in = 1'b0;
               end else if (mode_ff == MODE_RAW) begin
                  est_in  = rpm_w;
                  var_in  = INIT_VAR;
                  strk_in = '0;
                  upd_in  = upd_inc_w;
                  flag_in = 1'b1;
               end else if (legacy_w) begin
                  q_in    = LEGACY_Q;
                  busy_in = 1'b1;
                  kind_in = U_DIV;
                  cnt_in  = DIV_LAST;
                  rem_in  = '0;
                  dn_in   = {24'b0, mbase_ff};
                  dd_in   = {32'b0, per_w};
                  state_in = ST_R7;
               end else if (upd_ff == '0) begin
                  // First smooth item: adopt as is
                  est_in  = rpm_w;
                  var_in  = INIT_VAR;
                  upd_in  = 16'd1;
                  flag_in = 1'b1;
               end else begin
                  busy_in = 1'b1;
                  kind_in = U_MUL;
                  cnt_in  = MUL_LAST;
                  acc_in  = '0;
                  ma_in   = {16'b0, prate_ff};
                  mb_in   = {9'b0, dtc_w};
                  state_in = ST_Q1;
               end
            end
         end
         ST_Q1: if (!busy_ff) begin
            busy_in = 1'b1;
            kind_in = U_DIV;
            cnt_in  = DIV_LAST;
            rem_in  = '0;
            dn_in   = acc_ff[DN_W-1:0];
            dd_in   = US_PER_MS;
            state_in = ST_Q2;
         end
         ST_Q2: if (!busy_ff) begin
            q_in    = (dn_ff[VAR_W-1:0] < Q_FLOOR) ? Q_FLOOR : dn_ff[VAR_W-1:0];
            busy_in = 1'b1;
            kind_in = U_MUL;
            cnt_in  = MUL_LAST;
            acc_in  = '0;
            ma_in   = {32'b0, cvar_ff};
            mb_in   = {8'b0, meas_ff};
            state_in = ST_R0;
         end
         ST_R0: if (!busy_ff) begin
            tmp_in  = acc_ff[35:16];
            busy_in = 1'b1;
            kind_in = U_MUL;
            cnt_in  = MUL_LAST;
            acc_in  = '0;
            ma_in   = {18'b0, MEAS_DEN_K};
            mb_in   = {18'b0, p_w};
            state_in = ST_R1;
         end
         ST_R1: if (!busy_ff) begin
            dd_in   = acc_ff[DD_W-1:0];
            busy_in = 1'b1;
            kind_in = U_MUL;
            cnt_in  = MUL_LAST;
            acc_in  = '0;
            ma_in   = {32'b0, jit_ff};
            mb_in   = {8'b0, meas_ff};
            state_in = ST_R2;
         end
         ST_R2: if (!busy_ff) begin
            busy_in = 1'b1;
            kind_in = U_MUL;
            cnt_in  = MUL_LAST;
            acc_in  = '0;
            ma_in   = acc_ff[MA_W-1:0];
            mb_in   = {8'b0, meas_ff};
            state_in = ST_R3;
         end
         ST_R3: if (!busy_ff) begin
            busy_in = 1'b1;
            kind_in = U_DIV;
            cnt_in  = DIV_LAST;
            rem_in  = '0;
            dn_in   = acc_ff[DN_W-1:0];
            state_in = ST_R4;
         end
         ST_R4: if (!busy_ff) begin
            busy_in = 1'b1;
            kind_in = U_MUL;
            cnt_in  = MUL_LAST;
            acc_in  = '0;
            ma_in   = {20'b0, s_w};
            mb_in   = s_w;
            state_in = ST_R5;
         end
         ST_R5: if (!busy_ff) begin
            busy_in = 1'b1;
            kind_in = U_DIV;
            cnt_in  = DIV_LAST;
            rem_in  = '0;
            dn_in   = {8'b0, x_w};
            dd_in   = {32'b0, nper_ff};
            state_in = ST_R7;
         end
         ST_R7: if (!busy_ff) begin
            r_in = dn_ff[VAR_W-1:0];
            if (!legacy_w && upd_ff >= GATE_PRIME_UPDATES) begin
               busy_in = 1'b1;
               kind_in = U_SQRT;
               cnt_in  = SQRT_LAST;
               rem_in  = '0;
               mb_in   = '0;
               dn_in   = {4'b0, sat_add(var_q_w, dn_ff[VAR_W-1:0]), 4'b0};
               state_in = ST_G0;
            end else begin
               state_in = ST_P0;
            end
         end
         ST_G0: if (!busy_ff) begin
            // Root stays in mb as the multiplier
            busy_in = 1'b1;
            kind_in = U_MUL;
            cnt_in  = MUL_LAST;
            acc_in  = '0;
            ma_in   = {40'b0, gsig_ff};
            state_in = ST_G1;
         end
         ST_G1: if (!busy_ff) begin
            if (outlier_w) begin
               rej_in   = rej_inc_w;
               state_in = ST_FIN;
               if (strk_inc_w < gmax_ff) begin
                  strk_in = strk_inc_w;
                  flag_in = 1'b0;
               end else begin
                  est_in  = meas_ff;
                  var_in  = INIT_VAR;
                  strk_in = '0;
                  upd_in  = upd_inc_w;
                  flag_in = 1'b1;
               end
            end else begin
               state_in = ST_P0;
            end
         end
         ST_P0: begin
            var_in   = var_q_w;
            strk_in  = '0;
            state_in = ST_P1;
         end
         ST_P1: begin
            if (den_w == '0) begin
               g_in     = ONE_Q24;
               state_in = ST_C0;
            end else begin
               ma_in    = var_ff;
               dn_in    = {8'b0, den_w};
               state_in = ST_N0;
            end
         end
         ST_N0: begin
            // Scale both down until the denominator fits 32 bits
            if (dn_ff[47:32] != 16'd0) begin
               dn_in = {1'b0, dn_ff[DN_W-1:1]};
               ma_in = {1'b0, ma_ff[MA_W-1:1]};
            end else begin
               busy_in = 1'b1;
               kind_in = U_DIV;
               cnt_in  = DIV_LAST;
               rem_in  = '0;
               dn_in   = {ma_ff[31:0], 24'b0};
               dd_in   = {8'b0, dn_ff[31:0]};
               state_in = ST_N1;
            end
         end
         ST_N1: if (!busy_ff) begin
            g_in     = g_w;
            state_in = ST_C0;
         end
         ST_C0: begin
            busy_in = 1'b1;
            kind_in = U_MUL;
            cnt_in  = MUL_LAST;
            acc_in  = '0;
            ma_in   = {28'b0, d_w};
            mb_in   = {3'b0, g_ff};
            state_in = ST_C1;
         end
         ST_C1: if (!busy_ff) begin
            est_in  = (meas_ff >= est_ff) ? est_ff + corr_w : est_ff - corr_w;
            busy_in = 1'b1;
            kind_in = U_MUL;
            cnt_in  = MUL_LAST;
            acc_in  = '0;
            ma_in   = var_ff;
            mb_in   = {3'b0, ONE_Q24 - g_ff};
            state_in = ST_V0;
         end
         ST_V0: if (!busy_ff) begin
            var_in   = vnew_w;
            upd_in   = upd_inc_w;
            flag_in  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b0, strk_ff, rej_ff, var_ff, est_ff, flag_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/gskrf_checker.sv
module gskrf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);
   import gskrf_pkg::*;

   // One item in flight: no second accept straight after the first
   a_single: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while another is in work");

   // An updated estimate always clears the strike run
   a_strikes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[92:85] == 8'd0))
      else $error("accepted item with strikes pending");

   // Variance never drops under its floor
   a_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[68:21] >= P_FLOOR))
      else $error("variance below floor");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind gated_scalar_kalman_rpm_filter gskrf_checker u_gskrf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: sim/tb_gated_scalar_kalman_rpm_filter.sv
`timescale 1ns / 100ps

module tb_gated_scalar_kalman_rpm_filter;
   import gskrf_pkg::*;

   // One measurement item as it travels on the request channel
   typedef struct packed {
      logic        op;
      logic [19:0] rpm;
      logic [7:0]  periods;
      logic [23:0] dt;
   } meas_item_t;

   // One filter result, field by field
   typedef struct {
      bit        acc;
      bit [19:0] est;
      bit [47:0] pvar;
      bit [15:0] rej;
      bit [7:0]  strk;
   } filt_result_t;

   localparam bit [63:0] VAR_LIMIT  = 64'hFFFF_FFFF_FFFF;
   localparam bit [63:0] INIT_P     = 64'd6400;
   localparam bit [63:0] FIXED_Q    = 64'd400;
   localparam bit [63:0] NOISE_MIN  = 64'd16;
   localparam bit [63:0] P_MIN      = 64'd16;
   localparam bit [63:0] GAIN_ONE   = 64'd1 << 24;
   localparam bit [31:0] DT_CLAMP   = 32'd500000;
   localparam int        IDLE_LIMIT = 20000;
   localparam int        LONG_HOLD  = 5000;
   localparam int        DRAIN_WAIT = 600;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   gated_scalar_kalman_rpm_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the control registers (changed only while the filter is idle)
   bit [1:0]  cfg_mode   = MODE_SMOOTH;
   bit [9:0]  cfg_rpp    = 10'd256;
   bit [31:0] cfg_rate   = 32'd16000;
   bit [31:0] cfg_base   = 32'd1600;
   bit [15:0] cfg_jitter = 16'd256;
   bit [15:0] cfg_cycvar = 16'd655;
   bit [7:0]  cfg_gsig   = 8'd48;
   bit [7:0]  cfg_gmax   = 8'd3;

   // Predicted filter state
   bit [19:0] est_rpm   = '0;
   bit [63:0] est_var   = INIT_P;
   bit [15:0] upd_count = '0;
   bit [7:0]  strike_no = '0;
   bit [15:0] reject_no = '0;

   meas_item_t   pending_q[$];
   filt_result_t expected_q[$];

   int  gap_left, stall_left, hold_left;
   int  hold_asked, hold_seen;
   bit  calm;
   int  mismatches, items_in, results_out, outliers_seen, idle_cycles;

   function automatic bit [63:0] var_clamp(bit [63:0] a);
      return a > VAR_LIMIT ? VAR_LIMIT : a;
   endfunction

   function automatic bit [63:0] var_add(bit [63:0] a, bit [63:0] b);
      bit [63:0] x, y;
      x = var_clamp(a);
      y = var_clamp(b);
      return (y > VAR_LIMIT - x) ? VAR_LIMIT : x + y;
   endfunction

   function automatic bit [63:0] int_root(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // Take the measurement as the new estimate and restart the variance
   function automatic void adopt_reading(bit [19:0] m);
      est_rpm   = m;
      est_var   = INIT_P;
      strike_no = 0;
      if (upd_count != 16'hFFFF) upd_count++;
   endfunction

   // Advance the predicted filter by one item and return the result it yields
   function automatic filt_result_t kalman_predict(meas_item_t m);
      filt_result_t o;
      bit        acc, legacy, settled;
      bit [63:0] q, r, den, pn, dn, g, d, corr, sum, sq, rpp, t1, t2, s, s2, mv;
      bit [31:0] dtc;
      acc = 0;
      settled = 0;
      mv = m.rpm;
      if (m.op == OP_STOP) begin
         est_rpm   = 0;
         est_var   = INIT_P;
         upd_count = 0;
         strike_no = 0;
      end else if (m.periods != 0) begin
         acc = 1;
         legacy = (cfg_mode == MODE_LEGACY);
         if (cfg_mode == MODE_RAW) begin
            adopt_reading(m.rpm);
            settled = 1;
         end else if (!legacy && upd_count == 0) begin
            est_rpm   = m.rpm;
            est_var   = INIT_P;
            upd_count = 1;
            settled   = 1;
         end
         if (!settled) begin
            // process noise
            if (legacy) begin
               q = FIXED_Q;
            end else begin
               dtc = m.dt > DT_CLAMP ? DT_CLAMP : 32'(m.dt);
               q = var_clamp((64'(cfg_rate) * 64'(dtc)) / 64'd1000);
               if (q < NOISE_MIN) q = NOISE_MIN;
            end
            // measurement noise
            if (legacy) begin
               r = 64'(cfg_base) / 64'(m.periods);
            end else begin
               rpp = cfg_rpp != 0 ? 64'(cfg_rpp) : 64'd256;
               t1 = (64'(cfg_jitter) * mv * mv) / (64'd960000000 * rpp);
               t2 = (64'(cfg_cycvar) * mv) >> 16;
               s  = t1 + t2;
               s2 = (s * s) >> 4;
               r  = var_add(64'(cfg_base), s2) / 64'(m.periods);
            end
            // sigma gate, once the filter has settled in
            if (!legacy && upd_count >= 16'd4) begin
               sum = var_add(var_add(est_var, q), r);
               if (sum > (64'hFFFF_FFFF_FFFF_FFFF >> 4)) sum = 64'hFFFF_FFFF_FFFF_FFFF >> 4;
               sq = int_root(sum << 4);
               d = mv >= est_rpm ? mv - est_rpm : est_rpm - mv;
               if (d * 16 > 64'(cfg_gsig) * sq) begin
                  outliers_seen++;
                  if (reject_no != 16'hFFFF) reject_no++;
                  if (strike_no != 8'hFF) strike_no++;
                  if (strike_no < cfg_gmax) acc = 0;
                  else adopt_reading(m.rpm);
                  settled = 1;
               end
            end
         end
         if (!settled) begin
            strike_no = 0;
            est_var = var_add(est_var, q);
            den = var_add(est_var, r);
            if (den == 0) begin
               g = GAIN_ONE;
            end else begin
               pn = est_var;
               dn = den;
               while ((dn >> 32) != 0) begin
                  dn >>= 1;
                  pn >>= 1;
               end
               g = (pn << 24) / dn;
               if (g > GAIN_ONE) g = GAIN_ONE;
            end
            d = mv >= est_rpm ? mv - est_rpm : est_rpm - mv;
            corr = (d * g + (GAIN_ONE >> 1)) >> 24;
            if (corr > d) corr = d;
            if (mv >= est_rpm) est_rpm = est_rpm + 20'(corr);
            else est_rpm = est_rpm - 20'(corr);
            est_var = (est_var >> 24) * (GAIN_ONE - g)
                      + (((est_var & 64'hFF_FFFF) * (GAIN_ONE - g)) >> 24);
            if (est_var < P_MIN) est_var = P_MIN;
            if (upd_count != 16'hFFFF) upd_count++;
         end
      end
      o.acc  = acc;
      o.est  = est_rpm;
      o.pvar = 48'(var_clamp(est_var));
      o.rej  = reject_no;
      o.strk = strike_no;
      return o;
   endfunction

   // Gap lengths: mostly none or short, now and then long
   function automatic int pick_gap();
      int p;
      if (calm) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // Request driver: hold an offered item until it is taken, then predict it
   always @(posedge clock) begin
      bit took;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         took = req_tvalid && req_tready;
         if (took) begin
            expected_q.push_back(kalman_predict(pending_q.pop_front()));
            items_in++;
         end
         if (req_tvalid && !took) begin
            // hold the item on the bus
         end else if (gap_left > 0) begin
            req_tvalid <= 1'b0;
            gap_left   <= gap_left - 1;
         end else if (pending_q.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_q[0].op;
            req_tdata  <= {4'b0, pending_q[0].dt, pending_q[0].periods, pending_q[0].rpm};
            gap_left   <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: random back-pressure, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
         hold_seen  <= 0;
      end else if (hold_seen != hold_asked) begin
         hold_seen  <= hold_asked;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   // Result checker and watchdog
   always @(posedge clock) begin
      filt_result_t want;
      bit bad;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, expected_q.size());
            $display("FAILED: results differ");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_out++;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result %h", $realtime, rsp_tdata);
            end else begin
               want = expected_q.pop_front();
               bad = (rsp_tdata[0] !== want.acc) || (rsp_tdata[20:1] !== want.est) ||
                     (rsp_tdata[68:21] !== want.pvar) || (rsp_tdata[84:69] !== want.rej) ||
                     (rsp_tdata[92:85] !== want.strk);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: result %0d exp acc=%0d est=%h var=%h rej=%0d strk=%0d",
                               " got acc=%0d est=%h var=%h rej=%0d strk=%0d"},
                              $realtime, results_out, want.acc, want.est, want.pvar,
                              want.rej, want.strk, rsp_tdata[0], rsp_tdata[20:1],
                              rsp_tdata[68:21], rsp_tdata[84:69], rsp_tdata[92:85]);
               end
            end
         end
      end
   end

   // Write one control register and mirror it in the shadow copy
   task automatic write_reg(reg_index_type idx, bit [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_MODE:      cfg_mode   = value[1:0];
         REG_RPP:       cfg_rpp    = value[9:0];
         REG_PROC_RATE: cfg_rate   = value;
         REG_MEAS_BASE: cfg_base   = value;
         REG_JITTER:    cfg_jitter = value[15:0];
         REG_CYCLE_VAR: cfg_cycvar = value[15:0];
         REG_GATE_SIG:  cfg_gsig   = value[7:0];
         REG_GATE_MAX:  cfg_gmax   = value[7:0];
         default: ;
      endcase
      // Let the idle cycle land before the next write is offered
      @(posedge clock);
   endtask

   task automatic queue_item(bit op, bit [19:0] rpm, bit [7:0] periods, bit [23:0] dt);
      meas_item_t m;
      m.op = op;
      m.rpm = rpm;
      m.periods = periods;
      m.dt = dt;
      pending_q.push_back(m);
   endtask

   // Wait until every queued item has gone in and every result has come back
   task automatic drain();
      do @(posedge clock); while (pending_q.size() != 0 || expected_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Random run: mostly a drifting engine speed, with outliers, stops and empty items
   task automatic random_run(int count, bit wide);
      int unsigned base_rpm, p, delta;
      bit [19:0] rpm;
      base_rpm = wide ? $urandom_range(0, 20'hFFFFF) : $urandom_range(8000, 120000);
      repeat (count) begin
         p = $urandom_range(0, 99);
         delta = $urandom_range(0, 400);
         if ($urandom_range(0, 1)) base_rpm = base_rpm + delta / 8;
         else if (base_rpm > delta / 8) base_rpm = base_rpm - delta / 8;
         if (base_rpm > 20'hFFFFF) base_rpm = 20'hFFFFF;
         rpm = 20'(base_rpm + delta - 200 > 20'hFFFFF ? base_rpm : base_rpm + delta - 200);
         if (base_rpm < 200) rpm = 20'(base_rpm + delta);
         if (p < 3)
            queue_item(OP_STOP, 20'($urandom), 8'($urandom), 24'($urandom));
         else if (p < 7)
            queue_item(OP_MEASURE, 20'($urandom), 8'd0, 24'($urandom));
         else if (p < 15)
            queue_item(OP_MEASURE, 20'($urandom_range(0, 20'hFFFFF)),
                       8'($urandom_range(1, 255)), 24'($urandom_range(0, 24'hFFFFFF)));
         else if (p < 22)
            queue_item(OP_MEASURE, rpm, 8'($urandom_range(1, 255)),
                       24'($urandom_range(0, 24'hFFFFFF)));
         else
            queue_item(OP_MEASURE, rpm, 8'($urandom_range(1, 8)),
                       24'($urandom_range(1000, 60000)));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings (smooth gated filter)
      queue_item(OP_STOP, 20'hFFFFF, 8'hFF, 24'hFFFFFF);         // stop op, all ones
      queue_item(OP_MEASURE, 20'd16000, 8'd0, 24'd20000);        // no periods
      queue_item(OP_MEASURE, 20'd16000, 8'd1, 24'd20000);        // first reading adopted
      queue_item(OP_MEASURE, 20'd16100, 8'd255, 24'd0);
      queue_item(OP_MEASURE, 20'd15950, 8'd2, 24'hFFFFFF);       // long gap clamped
      queue_item(OP_MEASURE, 20'd16050, 8'd4, 24'd10000);
      queue_item(OP_MEASURE, 20'hFFFFF, 8'd1, 24'd10000);        // outliers in a row
      queue_item(OP_MEASURE, 20'd0, 8'd1, 24'd10000);
      queue_item(OP_MEASURE, 20'hFFFFF, 8'd1, 24'd10000);        // adopted on last strike
      queue_item(OP_MEASURE, 20'hFFFF0, 8'd3, 24'd20000);
      queue_item(OP_MEASURE, 20'd100, 8'd1, 24'd20000);          // single outlier
      queue_item(OP_MEASURE, 20'hFFFE0, 8'd1, 24'd20000);        // clears the strikes
      queue_item(OP_STOP, 20'd0, 8'd0, 24'd0);                   // keeps reject total
      queue_item(OP_MEASURE, 20'd0, 8'd1, 24'd0);
      queue_item(OP_MEASURE, 20'd0, 8'd1, 24'd1);
      drain();

      random_run(110, 0);
      drain();

      // Raw copy
      write_reg(REG_MODE, 32'(MODE_RAW));
      random_run(60, 1);
      drain();

      // Fixed-noise filter, both ends of the base noise
      write_reg(REG_MODE, 32'(MODE_LEGACY));
      write_reg(REG_MEAS_BASE, 32'd0);
      random_run(70, 0);
      drain();
      write_reg(REG_MEAS_BASE, 32'hFFFFFFFF);
      random_run(60, 1);
      drain();

      // Unused mode code (smooth filter): low extremes, but jitter and cycle variance at maximum
      write_reg(REG_MODE, 32'd3);
      write_reg(REG_RPP, 32'd0);
      write_reg(REG_PROC_RATE, 32'd0);
      write_reg(REG_MEAS_BASE, 32'd0);
      write_reg(REG_JITTER, 32'hFFFF);
      write_reg(REG_CYCLE_VAR, 32'hFFFF);
      write_reg(REG_GATE_SIG, 32'd1);
      write_reg(REG_GATE_MAX, 32'd1);
      random_run(100, 1);
      drain();

      // High extremes, but jitter and cycle variance at zero
      write_reg(REG_MODE, 32'(MODE_SMOOTH));
      write_reg(REG_RPP, 32'd1023);
      write_reg(REG_PROC_RATE, 32'hFFFFFFFF);
      write_reg(REG_MEAS_BASE, 32'hFFFFFFFF);
      write_reg(REG_JITTER, 32'd0);
      write_reg(REG_CYCLE_VAR, 32'd0);
      write_reg(REG_GATE_SIG, 32'd255);
      write_reg(REG_GATE_MAX, 32'd255);
      random_run(100, 1);
      drain();

      // Narrowest gate, adopt on any outlier
      write_reg(REG_RPP, 32'd1);
      write_reg(REG_PROC_RATE, 32'd16000);
      write_reg(REG_MEAS_BASE, 32'd1600);
      write_reg(REG_JITTER, 32'd256);
      write_reg(REG_CYCLE_VAR, 32'd655);
      write_reg(REG_GATE_SIG, 32'd0);
      write_reg(REG_GATE_MAX, 32'd0);
      random_run(80, 0);
      drain();

      // Back to reset values; back-to-back traffic against a long receiver hold-off
      write_reg(REG_RPP, 32'd256);
      write_reg(REG_GATE_SIG, 32'd48);
      write_reg(REG_GATE_MAX, 32'd3);
      calm = 1;
      hold_asked = hold_asked + 1;
      random_run(110, 0);
      drain();
      calm = 0;

      write_reg(REG_MODE, 32'(MODE_LEGACY));
      random_run(60, 0);
      drain();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_q.size() != 0) mismatches++;
      $display("Covered %0d items over raw, fixed-noise and gated modes at register extremes,",
               items_in);
      $display("%0d results checked, %0d gated outliers, %0d mismatches",
               results_out, outliers_seen, mismatches);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
